>>> rtl/nfpa_pkg.sv
// Shared widths, request and status codes and the map store command for the
// next-fit page allocator. No dependencies.
package nfpa_pkg;

   localparam int WORD_W    = 32;
   localparam int BIT_W     = 5;
   localparam int ROW_W     = 2 * WORD_W;
   localparam int PAGE_W    = 11;
   localparam int IDX_W     = 10;
   localparam int WADDR_W   = IDX_W - BIT_W;
   localparam int MAX_PAGES = 1 << IDX_W;

   localparam logic [PAGE_W-1:0] RESET_PAGE_COUNT = 11'd1024;
   localparam logic [IDX_W-1:0]  RESET_FIRST_USER = 10'd256;

   typedef enum logic [1:0] {
      REQ_ALLOC = 2'd0,
      REQ_FREE  = 2'd1,
      REQ_MARK  = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_NONE  = 2'd1,
      STAT_RANGE = 2'd2
   } status_code_type;

   typedef enum logic {
      CSR_PAGE_COUNT = 1'b0,
      CSR_FIRST_USER = 1'b1
   } csr_index_type;

   // A row holds the usable bits of 32 pages in its upper half and their
   // allocated bits in its lower half.
   typedef struct packed {
      logic               re;
      logic [WADDR_W-1:0] raddr;
      logic               we;
      logic [WADDR_W-1:0] waddr;
      logic [ROW_W-1:0]   wdata;
   } mem_cmd_type;

endpackage

>>> rtl/nfpa_req_if.sv
// Request channel of the next-fit page allocator: valid, ready and payload.
// Depends on nfpa_pkg for the page index width.
interface nfpa_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                req_type;
   logic [nfpa_pkg::IDX_W-1:0] page_index;
   logic                      usable_flag;

   modport source (output valid, req_type, page_index, usable_flag, input ready);
   modport sink   (input valid, req_type, page_index, usable_flag, output ready);
endinterface

>>> rtl/nfpa_rsp_if.sv
// Response channel of the next-fit page allocator: valid, ready and payload.
// Depends on nfpa_pkg for the page index width.
interface nfpa_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [nfpa_pkg::IDX_W-1:0] alloc_page;
   logic [1:0]                status;

   modport source (output valid, alloc_page, status, input ready);
   modport sink   (input valid, alloc_page, status, output ready);
endinterface

>>> rtl/nfpa_map_store.sv
// Synchronous map store: one row of usable and allocated bits per 32 pages,
// registered read, per-row valid bits cleared at reset. Uses nfpa_pkg.
module nfpa_map_store #(
   parameter int DEPTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  nfpa_pkg::mem_cmd_type         cmd,
   output logic [nfpa_pkg::ROW_W-1:0]    rdata
);
   import nfpa_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [ROW_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0] row_valid_ff;
   logic [DEPTH-1:0] row_valid_in;
   logic [ROW_W-1:0] q_ff;
   logic             q_valid_ff;

   always_comb begin
      row_valid_in = row_valid_ff;
      if (cmd.we) begin
         row_valid_in[cmd.waddr[AW-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else begin
         row_valid_ff <= row_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.waddr[AW-1:0]] <= cmd.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.re) begin
         q_ff       <= mem[cmd.raddr[AW-1:0]];
         q_valid_ff <= row_valid_ff[cmd.raddr[AW-1:0]];
      end
   end

   // A row never written since reset reads as all clear.
   assign rdata = q_valid_ff ? q_ff : '0;

endmodule

>>> rtl/nfpa_word_scan.sv
// Searches one map row for the lowest usable, free page inside a page window
// and returns the row with that page marked allocated. Uses nfpa_pkg.
module nfpa_word_scan (
   input  logic [nfpa_pkg::ROW_W-1:0]   row,
   input  logic [nfpa_pkg::WADDR_W-1:0] waddr,
   input  logic [nfpa_pkg::PAGE_W-1:0]  lo,
   input  logic [nfpa_pkg::PAGE_W-1:0]  hi,
   output logic                         hit,
   output logic [nfpa_pkg::PAGE_W-1:0]  page,
   output logic [nfpa_pkg::ROW_W-1:0]   new_row
);
   import nfpa_pkg::*;

   logic [WORD_W-1:0] usable_w;
   logic [WORD_W-1:0] alloc_w;
   logic [WORD_W-1:0] window;
   logic [WORD_W-1:0] avail;
   logic [WORD_W-1:0] lowest;
   logic [BIT_W-1:0]  pos;

   assign usable_w = row[ROW_W-1:WORD_W];
   assign alloc_w  = row[WORD_W-1:0];

   always_comb begin
      logic [PAGE_W-1:0] page_j;
      page_j = '0;
      for (int j = 0; j < WORD_W; j++) begin
         page_j    = {{(PAGE_W-IDX_W){1'b0}}, waddr, BIT_W'(j)};
         window[j] = (page_j >= lo) && (page_j < hi);
      end
   end

   assign avail  = usable_w & ~alloc_w & window;
   assign lowest = avail & (~avail + 1'b1);
   assign hit    = |avail;

   always_comb begin
      pos = '0;
      for (int j = 0; j < WORD_W; j++) begin
         if (lowest[j]) begin
            pos = pos | BIT_W'(j);
         end
      end
   end

   assign page    = {{(PAGE_W-IDX_W){1'b0}}, waddr, pos};
   assign new_row = {usable_w, alloc_w | lowest};

endmodule

>>> rtl/next_fit_page_allocator.sv
// Next-fit page allocator. An in-range free or mark request reads its map row and writes it
// back before it answers; an out-of-range one or an unused code answers without a map access.
// An allocate reads map rows from the next-fit pointer on, wraps to the first user page if that
// finds nothing, and reports none found after both; at most 33 rows of 32 pages are read.
// One request is in progress at a time; a finished response waits in an output register.
// Synchronous reset clears the row valid bits so both maps read empty, and sets page count
// 1024, first user page 256 and the next-fit pointer to 256.
module next_fit_page_allocator #(
   parameter int NUM_PAGES = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   nfpa_req_if.sink                     req_ch,
   nfpa_rsp_if.source                   rsp_ch,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [nfpa_pkg::PAGE_W-1:0]  csr_wdata
);
   import nfpa_pkg::*;

   localparam int STORE_PAGES = (NUM_PAGES < MAX_PAGES) ? NUM_PAGES : MAX_PAGES;
   localparam int WORDS       = (STORE_PAGES + WORD_W - 1) / WORD_W;
   localparam int COUNT_MAX   = (1 << PAGE_W) - 1;
   localparam int CAP_INT     = (NUM_PAGES < COUNT_MAX) ? NUM_PAGES : COUNT_MAX;
   localparam logic [PAGE_W-1:0] COUNT_CAP = PAGE_W'(CAP_INT);
   localparam logic [PAGE_W-1:0] STORE_CAP = PAGE_W'(STORE_PAGES);

   typedef enum logic [4:0] {
      IDLE   = 5'b00001,
      START  = 5'b00010,
      SCAN   = 5'b00100,
      MODIFY = 5'b01000,
      DONE   = 5'b10000
   } fsm_state_type;

   fsm_state_type       state_ff, state_in;
   logic [PAGE_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]    fup_ff, fup_in;
   logic [PAGE_W-1:0]   ptr_ff, ptr_in;
   logic [1:0]          op_ff, op_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                flag_ff, flag_in;
   logic                seg_ff, seg_in;
   logic [PAGE_W-1:0]   lo_ff, lo_in;
   logic [PAGE_W-1:0]   hi_ff, hi_in;
   logic [WADDR_W-1:0]  addr_ff, addr_in;
   logic [WADDR_W-1:0]  last_ff, last_in;
   logic                iss_done_ff, iss_done_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [WADDR_W-1:0]  rd_addr_ff, rd_addr_in;
   logic [IDX_W-1:0]    res_page_ff, res_page_in;
   logic [1:0]          res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]    rsp_page_ff, rsp_page_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;

   logic [PAGE_W-1:0]   cnt_eff;
   logic [PAGE_W-1:0]   hi1;
   logic [PAGE_W-1:0]   hi2;
   logic [PAGE_W-1:0]   seg_lo;
   logic [PAGE_W-1:0]   seg_hi;
   logic [PAGE_W-1:0]   seg_hi_m1;
   logic                req_acc;
   logic                idx_ok;
   mem_cmd_type         mem_cmd;
   logic [ROW_W-1:0]    mem_rdata;
   logic                scan_hit;
   logic [PAGE_W-1:0]   scan_page;
   logic [ROW_W-1:0]    scan_row;
   logic [WORD_W-1:0]   mod_usable;
   logic [WORD_W-1:0]   mod_alloc;

   nfpa_map_store #(.DEPTH(WORDS)) u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (mem_cmd),
      .rdata (mem_rdata)
   );

   nfpa_word_scan u_scan (
      .row     (mem_rdata),
      .waddr   (rd_addr_ff),
      .lo      (lo_ff),
      .hi      (hi_ff),
      .hit     (scan_hit),
      .page    (scan_page),
      .new_row (scan_row)
   );

   assign cnt_eff   = (count_ff > COUNT_CAP) ? COUNT_CAP : count_ff;
   assign hi1       = (cnt_eff > STORE_CAP) ? STORE_CAP : cnt_eff;
   assign hi2       = (ptr_ff < hi1) ? ptr_ff : hi1;
   assign seg_lo    = seg_ff ? {{(PAGE_W-IDX_W){1'b0}}, fup_ff} : ptr_ff;
   assign seg_hi    = seg_ff ? hi2 : hi1;
   assign seg_hi_m1 = seg_hi - 1'b1;
   assign req_acc   = req_ch.valid && req_ch.ready;
   assign idx_ok    = {{(PAGE_W-IDX_W){1'b0}}, req_ch.page_index} < cnt_eff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      fup_in        = fup_ff;
      ptr_in        = ptr_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      flag_in       = flag_ff;
      seg_in        = seg_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      addr_in       = addr_ff;
      last_in       = last_ff;
      iss_done_in   = iss_done_ff;
      rd_pend_in    = rd_pend_ff;
      rd_addr_in    = rd_addr_ff;
      res_page_in   = res_page_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_status_in = rsp_status_ff;
      mem_cmd       = '0;
      mod_usable    = mem_rdata[ROW_W-1:WORD_W];
      mod_alloc     = mem_rdata[WORD_W-1:0];

      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PAGE_COUNT: begin
               count_in = csr_wdata;
            end
            CSR_FIRST_USER: begin
               fup_in = csr_wdata[IDX_W-1:0];
            end
            default: begin
            end
         endcase
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         IDLE: begin
            if (req_acc) begin
               op_in         = req_ch.req_type;
               idx_in        = req_ch.page_index;
               flag_in       = req_ch.usable_flag;
               res_page_in   = '0;
               res_status_in = STAT_OK;
               case (req_code_type'(req_ch.req_type))
                  REQ_ALLOC: begin
                     seg_in   = 1'b0;
                     state_in = START;
                  end
                  REQ_FREE, REQ_MARK: begin
                     if (idx_ok) begin
                        mem_cmd.re    = 1'b1;
                        mem_cmd.raddr = req_ch.page_index[IDX_W-1:BIT_W];
                        state_in      = MODIFY;
                     end else begin
                        res_status_in = STAT_RANGE;
                        state_in      = DONE;
                     end
                  end
                  default: begin
                     state_in = DONE;
                  end
               endcase
            end
         end
         START: begin
            if (seg_lo < seg_hi) begin
               lo_in       = seg_lo;
               hi_in       = seg_hi;
               addr_in     = seg_lo[IDX_W-1:BIT_W];
               last_in     = seg_hi_m1[IDX_W-1:BIT_W];
               iss_done_in = 1'b0;
               rd_pend_in  = 1'b0;
               state_in    = SCAN;
            end else if (!seg_ff) begin
               seg_in = 1'b1;
            end else begin
               res_status_in = STAT_NONE;
               state_in      = DONE;
            end
         end
         SCAN: begin
            rd_pend_in = 1'b0;
            if (!iss_done_ff) begin
               mem_cmd.re    = 1'b1;
               mem_cmd.raddr = addr_ff;
               rd_pend_in    = 1'b1;
               rd_addr_in    = addr_ff;
               if (addr_ff == last_ff) begin
                  iss_done_in = 1'b1;
               end else begin
                  addr_in = addr_ff + 1'b1;
               end
            end
            if (rd_pend_ff && scan_hit) begin
               mem_cmd.we    = 1'b1;
               mem_cmd.waddr = rd_addr_ff;
               mem_cmd.wdata = scan_row;
               ptr_in        = scan_page + 1'b1;
               res_page_in   = scan_page[IDX_W-1:0];
               state_in      = DONE;
            end else if (iss_done_ff && !rd_pend_ff) begin
               if (!seg_ff) begin
                  seg_in   = 1'b1;
                  state_in = START;
               end else begin
                  res_status_in = STAT_NONE;
                  state_in      = DONE;
               end
            end
         end
         MODIFY: begin
            if (op_ff == REQ_FREE) begin
               mod_alloc[idx_ff[BIT_W-1:0]] = 1'b0;
            end else begin
               mod_usable[idx_ff[BIT_W-1:0]] = flag_ff;
            end
            mem_cmd.we    = 1'b1;
            mem_cmd.waddr = idx_ff[IDX_W-1:BIT_W];
            mem_cmd.wdata = {mod_usable, mod_alloc};
            state_in      = DONE;
         end
         DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_page_in   = res_page_ff;
               rsp_status_in = res_status_ff;
               state_in      = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= RESET_PAGE_COUNT;
         fup_ff       <= RESET_FIRST_USER;
         ptr_ff       <= {{(PAGE_W-IDX_W){1'b0}}, RESET_FIRST_USER};
         seg_ff       <= 1'b0;
         iss_done_ff  <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         fup_ff       <= fup_in;
         ptr_ff       <= ptr_in;
         seg_ff       <= seg_in;
         iss_done_ff  <= iss_done_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      flag_ff       <= flag_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      addr_ff       <= addr_in;
      last_ff       <= last_in;
      rd_addr_ff    <= rd_addr_in;
      res_page_ff   <= res_page_in;
      res_status_ff <= res_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ch.ready      = (state_ff == IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.alloc_page = rsp_page_ff;
   assign rsp_ch.status     = rsp_status_ff;

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ch.ready)
      else $error("request accepted while another is in progress");

   a_single_bit_write: assert property (@(posedge clock) disable iff (reset)
      mem_cmd.we |-> $countones(mem_cmd.wdata ^ mem_rdata) <= 1)
      else $error("map write changes more than one bit");

   a_ptr_moves_on_hit: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && ptr_ff != $past(ptr_ff) |-> $past(mem_cmd.we && state_ff == SCAN))
      else $error("next-fit pointer moved without an allocation");

   a_ptr_past_page: assert property (@(posedge clock) disable iff (reset)
      state_ff == DONE && op_ff == REQ_ALLOC && res_status_ff == STAT_OK
      |-> ptr_ff == {{(PAGE_W-IDX_W){1'b0}}, res_page_ff} + 1'b1)
      else $error("pointer does not follow the allocated page");

endmodule

>>> test/tb.sv
// Self-checking testbench for next_fit_page_allocator: directed and random requests with a
// cycle-free predictor of both page maps and the next-fit pointer, and random idling.
// Depends on nfpa_pkg, nfpa_req_if and nfpa_rsp_if from the RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import nfpa_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int GAP_MAX = 19;

   typedef struct packed {
      logic [IDX_W-1:0] page;
      logic [1:0]       status;
   } grant_type;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic              csr_index;
   logic [PAGE_W-1:0] csr_wdata;

   nfpa_req_if req_ch ();
   nfpa_rsp_if rsp_ch ();

   next_fit_page_allocator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bit                allocated_pages [MAX_PAGES];
   bit                usable_pages [MAX_PAGES];
   logic [PAGE_W-1:0] next_fit;
   logic [PAGE_W-1:0] cfg_page_count;
   logic [IDX_W-1:0]  cfg_first_user;
   grant_type         grants_due [$];
   int                mismatches = 0;
   bit                no_idle;
   int                rsp_hold;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic int managed_pages();
      return (cfg_page_count > MAX_PAGES) ? MAX_PAGES : int'(cfg_page_count);
   endfunction

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, GAP_MAX);
   endfunction

   function automatic grant_type predict_grant(logic [1:0] kind, logic [IDX_W-1:0] idx,
                                               logic flag);
      int        count;
      int        wrap_hi;
      int        i;
      int        found;
      bit        hit;
      grant_type g;
      count = managed_pages();
      g.page = '0;
      g.status = STAT_OK;
      hit = 1'b0;
      found = 0;
      if (kind == REQ_ALLOC) begin
         wrap_hi = (next_fit < count) ? int'(next_fit) : count;
         for (i = int'(next_fit); i < count && !hit; i++) begin
            if (usable_pages[i] && !allocated_pages[i]) begin
               found = i;
               hit = 1'b1;
            end
         end
         for (i = int'(cfg_first_user); i < wrap_hi && !hit; i++) begin
            if (usable_pages[i] && !allocated_pages[i]) begin
               found = i;
               hit = 1'b1;
            end
         end
         if (hit) begin
            allocated_pages[found] = 1'b1;
            next_fit = PAGE_W'(found + 1);
            g.page = IDX_W'(found);
         end else begin
            g.status = STAT_NONE;
         end
      end else if (kind == REQ_FREE || kind == REQ_MARK) begin
         if (idx >= count) begin
            g.status = STAT_RANGE;
         end else if (kind == REQ_FREE) begin
            allocated_pages[idx] = 1'b0;
         end else begin
            usable_pages[idx] = flag;
         end
      end
      return g;
   endfunction

   task automatic send_request(input logic [1:0] kind, input logic [IDX_W-1:0] idx,
                               input logic flag);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.req_type    <= kind;
      req_ch.page_index  <= idx;
      req_ch.usable_flag <= flag;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      grants_due.push_back(predict_grant(kind, idx, flag));
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (grants_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_registers(input logic [PAGE_W-1:0] count,
                                    input logic [IDX_W-1:0] first);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= CSR_PAGE_COUNT;
      csr_wdata <= count;
      @(posedge clock);
      csr_index <= CSR_FIRST_USER;
      csr_wdata <= {1'b0, first};
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_page_count = count;
      cfg_first_user = first;
      @(posedge clock);
   endtask

   always @(posedge clock) begin : rsp_side
      grant_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (grants_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response, expected none, got page %0d status %0d",
                        $time, rsp_ch.alloc_page, rsp_ch.status);
            end else begin
               want = grants_due.pop_front();
               if (rsp_ch.alloc_page !== want.page) begin
                  mismatches++;
                  $display("%0t: alloc_page mismatch, expected %0d, got %0d",
                           $time, want.page, rsp_ch.alloc_page);
               end
               if (rsp_ch.status !== want.status) begin
                  mismatches++;
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, want.status, rsp_ch.status);
               end
            end
            rsp_hold = draw_gap();
            rsp_ch.ready <= (rsp_hold == 0);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ch.ready <= (rsp_hold == 0);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic test_reset_state();
      send_request(REQ_ALLOC, 10'd0, 1'b0);
      send_request(REQ_FREE, 10'd5, 1'b0);
      send_request(REQ_MARK, 10'd300, 1'b1);
      send_request(REQ_MARK, 10'd1023, 1'b1);
      send_request(REQ_MARK, 10'd0, 1'b1);
      send_request(REQ_ALLOC, 10'd1023, 1'b1);
      send_request(REQ_ALLOC, 10'd0, 1'b0);
      send_request(REQ_ALLOC, 10'd0, 1'b0);
      send_request(REQ_FREE, 10'd300, 1'b0);
      send_request(REQ_ALLOC, 10'd0, 1'b0);
      send_request(REQ_MARK, 10'd300, 1'b0);
      send_request(REQ_UNUSED, 10'd1023, 1'b1);
   endtask

   task automatic test_register_extremes();
      program_registers(11'd0, 10'd0);
      send_request(REQ_ALLOC, 10'd0, 1'b0);
      send_request(REQ_FREE, 10'd0, 1'b0);
      send_request(REQ_MARK, 10'd0, 1'b1);
      program_registers(11'd1, 10'd0);
      send_request(REQ_ALLOC, 10'd0, 1'b0);
      send_request(REQ_ALLOC, 10'd0, 1'b0);
      send_request(REQ_FREE, 10'd1, 1'b0);
      send_request(REQ_FREE, 10'd0, 1'b0);
      send_request(REQ_ALLOC, 10'd0, 1'b0);
      program_registers(11'd2047, 10'd1023);
      send_request(REQ_FREE, 10'd1023, 1'b0);
      send_request(REQ_ALLOC, 10'd0, 1'b0);
      send_request(REQ_ALLOC, 10'd0, 1'b0);
      send_request(REQ_MARK, 10'd1023, 1'b0);
   endtask

   task automatic test_random_traffic(input int phases, input int per_phase);
      int               p;
      int               n;
      int               roll;
      int               count;
      int               first;
      int               eff;
      logic [1:0]       kind;
      logic [IDX_W-1:0] idx;
      logic             flag;
      for (p = 0; p < phases; p++) begin
         roll = $urandom_range(0, 9);
         if (roll == 0) count = MAX_PAGES;
         else if (roll == 1) count = $urandom_range(MAX_PAGES + 1, 2047);
         else if (roll == 2) count = 1;
         else count = $urandom_range(2, 64);
         roll = $urandom_range(0, 9);
         if (roll == 0) first = 0;
         else if (roll == 1) first = MAX_PAGES - 1;
         else if (roll == 2) first = $urandom_range(0, MAX_PAGES - 1);
         else first = $urandom_range(0, ((count > MAX_PAGES) ? MAX_PAGES : count) - 1);
         program_registers(PAGE_W'(count), IDX_W'(first));
         no_idle = ($urandom_range(0, 3) == 0);
         for (n = 0; n < per_phase; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) kind = REQ_ALLOC;
            else if (roll < 60) kind = REQ_FREE;
            else if (roll < 94) kind = REQ_MARK;
            else kind = REQ_UNUSED;
            eff = managed_pages();
            if ($urandom_range(0, 9) < 8 && eff > 0) idx = IDX_W'($urandom_range(0, eff - 1));
            else idx = IDX_W'($urandom_range(0, MAX_PAGES - 1));
            flag = ($urandom_range(0, 3) != 0);
            send_request(kind, idx, flag);
            if ($urandom_range(0, 63) == 0) wait_drained();
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.req_type    = REQ_ALLOC;
      req_ch.page_index  = '0;
      req_ch.usable_flag = 1'b0;
      csr_we             = 1'b0;
      csr_index          = CSR_PAGE_COUNT;
      csr_wdata          = '0;
      no_idle            = 1'b0;
      next_fit           = {1'b0, RESET_FIRST_USER};
      cfg_page_count     = RESET_PAGE_COUNT;
      cfg_first_user     = RESET_FIRST_USER;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_register_extremes();
      test_random_traffic(10, 160);
      wait_drained();
      repeat (80) @(posedge clock);
      if (mismatches == 0 && grants_due.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
